// ===== hw/rtl/max_pooling_2d_with_argmax_top_defines.svh =====
// Assertion helpers for the max pooling block.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef MAX_POOLING_2D_WITH_ARGMAX_TOP_DEFINES_SVH
`define MAX_POOLING_2D_WITH_ARGMAX_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpa: same-cycle check failed");
`define MPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpa: next-cycle check failed");
`else
`define MPA_ASSERT_IMP(label, ante, cons)
`define MPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/mpa_pkg.sv =====
package mpa_pkg;

  // Sizing
  localparam int SAMPLE_WIDTH   = 16;
  localparam int MAX_FRAME_COLS = 256;
  localparam int MAX_WINDOW     = 8;
  localparam int MAX_ROWS       = 256;
  localparam int MAX_STRIDE     = 8;

  // Register field widths
  localparam int FRAME_REG_W = 9;
  localparam int WIN_REG_W   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  // Derived widths
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int RDIM_W     = $clog2(MAX_ROWS + 1);
  localparam int COL_W      = $clog2(MAX_FRAME_COLS);
  localparam int CDIM_RAW_W = $clog2(MAX_FRAME_COLS + 1);
  localparam int CDIM_W     = (CDIM_RAW_W > FRAME_REG_W) ? CDIM_RAW_W : FRAME_REG_W;
  localparam int CDIM1_W    = CDIM_W + 1;
  localparam int DIM_W      = (CDIM_W > RDIM_W) ? CDIM_W : RDIM_W;
  localparam int DIM1_W     = DIM_W + 1;
  localparam int WIN_W      = $clog2(MAX_WINDOW);
  localparam int SX_W       = WIN_REG_W + 1;
  localparam int POS_W      = $clog2(MAX_WINDOW * MAX_WINDOW);
  localparam int POS_OUT_W  = 6;
  localparam int PHASE_W    = 3;
  localparam int STORE_DEPTH = MAX_WINDOW * MAX_FRAME_COLS;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);

  // Reset values of the registers
  localparam logic [FRAME_REG_W-1:0] RST_FRAME_ROWS  = 9'd28;
  localparam logic [FRAME_REG_W-1:0] RST_FRAME_COLS  = 9'd28;
  localparam logic [WIN_REG_W-1:0]   RST_WINDOW_ROWS = 4'd2;
  localparam logic [WIN_REG_W-1:0]   RST_WINDOW_COLS = 4'd2;
  localparam logic [WIN_REG_W-1:0]   RST_STRIDE      = 4'd2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_ROWS  = 3'd0,
    REG_FRAME_COLS  = 3'd1,
    REG_WINDOW_ROWS = 3'd2,
    REG_WINDOW_COLS = 3'd3,
    REG_STRIDE      = 3'd4
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } mpa_state_t;

  // Clamped, ready-to-use configuration
  typedef struct packed {
    logic [RDIM_W-1:0]    rows;
    logic [CDIM_W-1:0]    cols;
    logic [WIN_REG_W-1:0] win_rows;
    logic [WIN_REG_W-1:0] win_cols;
    logic [WIN_REG_W-1:0] stride;
  } cfg_t;

  // Tag that travels with each line store read
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
  } rd_tag_t;

  // Result register control
  typedef struct packed {
    logic load;
    logic last_window;
  } res_ctl_t;

  // Stride phase step: phase only advances once a full window fits
  function automatic logic [PHASE_W-1:0] next_phase(
    input logic [DIM_W-1:0]     pos,
    input logic [WIN_REG_W-1:0] win,
    input logic [PHASE_W-1:0]   phase,
    input logic [WIN_REG_W-1:0] s
  );
    logic [DIM1_W-1:0]    pos_inc;
    logic [WIN_REG_W-1:0] ph_inc;
    pos_inc = DIM1_W'(pos) + DIM1_W'(1);
    ph_inc  = WIN_REG_W'(phase) + WIN_REG_W'(1);
    if (pos_inc < DIM1_W'(win)) begin
      return '0;
    end else if (ph_inc >= s) begin
      return '0;
    end else begin
      return PHASE_W'(ph_inc);
    end
  endfunction

endpackage

// ===== hw/rtl/mpa_in_if.sv =====
interface mpa_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [mpa_pkg::SAMPLE_WIDTH-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/mpa_out_if.sv =====
interface mpa_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [mpa_pkg::SAMPLE_WIDTH-1:0]  max_value;
  logic        [mpa_pkg::POS_OUT_W-1:0]     max_position;
  logic                                     last_window;

  modport source (output valid, output max_value, output max_position,
                  output last_window, input ready);
  modport sink   (input valid, input max_value, input max_position,
                  input last_window, output ready);
endinterface

// ===== hw/rtl/mpa_cfg_if.sv =====
interface mpa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mpa_pkg::CFG_IDX_W-1:0]     index;
  logic [mpa_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mpa_ram.sv =====
module mpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mpa_cfg.sv =====
module mpa_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_valid,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0] wr_data,
  output logic                           wr_ready,
  output mpa_pkg::cfg_t                  cfg,
  output logic                           restart
);

  logic [mpa_pkg::FRAME_REG_W-1:0] rows_r, rows_nxt;
  logic [mpa_pkg::FRAME_REG_W-1:0] cols_r, cols_nxt;
  logic [mpa_pkg::WIN_REG_W-1:0]   wrows_r, wrows_nxt;
  logic [mpa_pkg::WIN_REG_W-1:0]   wcols_r, wcols_nxt;
  logic [mpa_pkg::WIN_REG_W-1:0]   stride_r, stride_nxt;
  logic                            hit;

  logic [mpa_pkg::RDIM_W-1:0]    rows_c;
  logic [mpa_pkg::CDIM_W-1:0]    cols_c;
  logic [mpa_pkg::CDIM_W-1:0]    cols_ext;
  logic [mpa_pkg::WIN_REG_W-1:0] wr_c, wc_c;

  assign wr_ready = 1'b1;

  // Register write decode
  always_comb begin
    rows_nxt   = rows_r;
    cols_nxt   = cols_r;
    wrows_nxt  = wrows_r;
    wcols_nxt  = wcols_r;
    stride_nxt = stride_r;
    hit        = 1'b0;
    if (wr_valid) begin
      unique case (mpa_pkg::cfg_reg_t'(wr_index))
        mpa_pkg::REG_FRAME_ROWS: begin
          rows_nxt = wr_data[mpa_pkg::FRAME_REG_W-1:0];
          hit      = 1'b1;
        end
        mpa_pkg::REG_FRAME_COLS: begin
          cols_nxt = wr_data[mpa_pkg::FRAME_REG_W-1:0];
          hit      = 1'b1;
        end
        mpa_pkg::REG_WINDOW_ROWS: begin
          wrows_nxt = wr_data[mpa_pkg::WIN_REG_W-1:0];
          hit       = 1'b1;
        end
        mpa_pkg::REG_WINDOW_COLS: begin
          wcols_nxt = wr_data[mpa_pkg::WIN_REG_W-1:0];
          hit       = 1'b1;
        end
        mpa_pkg::REG_STRIDE: begin
          stride_nxt = wr_data[mpa_pkg::WIN_REG_W-1:0];
          hit        = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  // Any accepted write to a known register restarts the frame
  assign restart = hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= mpa_pkg::RST_FRAME_ROWS;
      cols_r   <= mpa_pkg::RST_FRAME_COLS;
      wrows_r  <= mpa_pkg::RST_WINDOW_ROWS;
      wcols_r  <= mpa_pkg::RST_WINDOW_COLS;
      stride_r <= mpa_pkg::RST_STRIDE;
    end else begin
      rows_r   <= rows_nxt;
      cols_r   <= cols_nxt;
      wrows_r  <= wrows_nxt;
      wcols_r  <= wcols_nxt;
      stride_r <= stride_nxt;
    end
  end

  // Clamp to supported ranges; window never exceeds the frame
  always_comb begin
    cols_ext = mpa_pkg::CDIM_W'(cols_r);
    if (rows_r == '0) begin
      rows_c = mpa_pkg::RDIM_W'(1);
    end else if (rows_r > mpa_pkg::FRAME_REG_W'(mpa_pkg::MAX_ROWS)) begin
      rows_c = mpa_pkg::RDIM_W'(mpa_pkg::MAX_ROWS);
    end else begin
      rows_c = mpa_pkg::RDIM_W'(rows_r);
    end

    if (cols_ext == '0) begin
      cols_c = mpa_pkg::CDIM_W'(1);
    end else if (cols_ext > mpa_pkg::CDIM_W'(mpa_pkg::MAX_FRAME_COLS)) begin
      cols_c = mpa_pkg::CDIM_W'(mpa_pkg::MAX_FRAME_COLS);
    end else begin
      cols_c = cols_ext;
    end

    if (wrows_r == '0) begin
      wr_c = mpa_pkg::WIN_REG_W'(1);
    end else if (wrows_r > mpa_pkg::WIN_REG_W'(mpa_pkg::MAX_WINDOW)) begin
      wr_c = mpa_pkg::WIN_REG_W'(mpa_pkg::MAX_WINDOW);
    end else begin
      wr_c = wrows_r;
    end
    if (mpa_pkg::RDIM_W'(wr_c) > rows_c) begin
      wr_c = rows_c[mpa_pkg::WIN_REG_W-1:0];
    end

    if (wcols_r == '0) begin
      wc_c = mpa_pkg::WIN_REG_W'(1);
    end else if (wcols_r > mpa_pkg::WIN_REG_W'(mpa_pkg::MAX_WINDOW)) begin
      wc_c = mpa_pkg::WIN_REG_W'(mpa_pkg::MAX_WINDOW);
    end else begin
      wc_c = wcols_r;
    end
    if (mpa_pkg::CDIM_W'(wc_c) > cols_c) begin
      wc_c = cols_c[mpa_pkg::WIN_REG_W-1:0];
    end

    cfg.rows     = rows_c;
    cfg.cols     = cols_c;
    cfg.win_rows = wr_c;
    cfg.win_cols = wc_c;
    if (stride_r == '0) begin
      cfg.stride = mpa_pkg::WIN_REG_W'(1);
    end else if (stride_r > mpa_pkg::WIN_REG_W'(mpa_pkg::MAX_STRIDE)) begin
      cfg.stride = mpa_pkg::WIN_REG_W'(mpa_pkg::MAX_STRIDE);
    end else begin
      cfg.stride = stride_r;
    end
  end

endmodule

// ===== hw/rtl/mpa_ctrl.sv =====
module mpa_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mpa_pkg::cfg_t                    cfg,
  input  logic                             restart,
  input  logic                             in_valid,
  input  logic [mpa_pkg::SAMPLE_WIDTH-1:0] in_sample,
  output logic                             in_ready,
  input  logic                             out_free,
  output logic                             ram_we,
  output logic [mpa_pkg::ADDR_W-1:0]       ram_waddr,
  output logic [mpa_pkg::SAMPLE_WIDTH-1:0] ram_wdata,
  output logic                             ram_re,
  output logic [mpa_pkg::ADDR_W-1:0]       ram_raddr,
  output mpa_pkg::rd_tag_t                 rd_tag,
  output mpa_pkg::res_ctl_t                res_ctl,
  output logic                             scan_active
);

  mpa_pkg::mpa_state_t state_r, state_nxt;

  // Frame position
  logic [mpa_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [mpa_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [mpa_pkg::PHASE_W-1:0] rph_r, rph_nxt;
  logic [mpa_pkg::PHASE_W-1:0] cph_r, cph_nxt;
  logic [mpa_pkg::WIN_W-1:0]   slot_r, slot_nxt;

  // Window scan
  logic [mpa_pkg::WIN_W-1:0]   sslot_r, sslot_nxt;
  logic [mpa_pkg::WIN_W-1:0]   ii_r, ii_nxt;
  logic [mpa_pkg::WIN_W-1:0]   jj_r, jj_nxt;
  logic [mpa_pkg::COL_W-1:0]   col0_r, col0_nxt;
  logic [mpa_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        lastw_r, lastw_nxt;
  mpa_pkg::rd_tag_t            tag_r, tag_nxt;

  logic                          accept;
  logic                          fire;
  logic                          scan_end;
  logic [mpa_pkg::RDIM_W-1:0]    r_inc;
  logic [mpa_pkg::CDIM_W-1:0]    c_inc;
  logic [mpa_pkg::SX_W-1:0]      sx, wm1, sstart;
  logic [mpa_pkg::CDIM_W-1:0]    scol;
  logic [mpa_pkg::WIN_W-1:0]     slot_inc;
  logic [mpa_pkg::WIN_W-1:0]     sslot_inc;

  function automatic logic [mpa_pkg::ADDR_W-1:0] store_addr(
    input logic [mpa_pkg::WIN_W-1:0] slot,
    input logic [mpa_pkg::COL_W-1:0] col
  );
    return mpa_pkg::ADDR_W'(slot) * mpa_pkg::ADDR_W'(mpa_pkg::MAX_FRAME_COLS)
           + mpa_pkg::ADDR_W'(col);
  endfunction

  assign accept = in_valid && in_ready;
  assign r_inc  = mpa_pkg::RDIM_W'(row_r) + mpa_pkg::RDIM_W'(1);
  assign c_inc  = mpa_pkg::CDIM_W'(col_r) + mpa_pkg::CDIM_W'(1);
  assign fire   = (r_inc >= mpa_pkg::RDIM_W'(cfg.win_rows)) &&
                  (c_inc >= mpa_pkg::CDIM_W'(cfg.win_cols)) &&
                  (rph_r == '0) && (cph_r == '0);
  assign scan_end = (mpa_pkg::WIN_REG_W'(ii_r) == cfg.win_rows - mpa_pkg::WIN_REG_W'(1)) &&
                    (mpa_pkg::WIN_REG_W'(jj_r) == cfg.win_cols - mpa_pkg::WIN_REG_W'(1));

  // Ring slot arithmetic for the line store rows
  assign slot_inc  = (slot_r == mpa_pkg::WIN_W'(mpa_pkg::MAX_WINDOW - 1)) ?
                     '0 : slot_r + mpa_pkg::WIN_W'(1);
  assign sslot_inc = (sslot_r == mpa_pkg::WIN_W'(mpa_pkg::MAX_WINDOW - 1)) ?
                     '0 : sslot_r + mpa_pkg::WIN_W'(1);
  assign sx  = mpa_pkg::SX_W'(slot_r);
  assign wm1 = mpa_pkg::SX_W'(cfg.win_rows) - mpa_pkg::SX_W'(1);
  assign sstart = (sx >= wm1) ? sx - wm1 : sx + mpa_pkg::SX_W'(mpa_pkg::MAX_WINDOW) - wm1;
  assign scol   = mpa_pkg::CDIM_W'(col0_r) + mpa_pkg::CDIM_W'(jj_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpa_pkg::ST_IDLE:  if (accept && fire) state_nxt = mpa_pkg::ST_SCAN;
      mpa_pkg::ST_SCAN:  if (scan_end) state_nxt = mpa_pkg::ST_DRAIN;
      mpa_pkg::ST_DRAIN: state_nxt = out_free ? mpa_pkg::ST_IDLE : mpa_pkg::ST_HOLD;
      mpa_pkg::ST_HOLD:  if (out_free) state_nxt = mpa_pkg::ST_IDLE;
      default:           state_nxt = mpa_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready    = 1'b0;
    ram_re      = 1'b0;
    res_ctl     = '0;
    scan_active = 1'b0;
    unique case (state_r) inside
      mpa_pkg::ST_IDLE: in_ready = 1'b1;
      mpa_pkg::ST_SCAN: begin
        ram_re      = 1'b1;
        scan_active = 1'b1;
      end
      mpa_pkg::ST_DRAIN, mpa_pkg::ST_HOLD: res_ctl.load = out_free;
      default: in_ready = 1'b0;
    endcase
    res_ctl.last_window = lastw_r;
  end

  // Sample write into the line store at the current position
  assign ram_we    = accept;
  assign ram_waddr = store_addr(slot_r, col_r);
  assign ram_wdata = in_sample;
  assign ram_raddr = store_addr(sslot_r, scol[mpa_pkg::COL_W-1:0]);

  // Frame counters and scan pointers
  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    rph_nxt   = rph_r;
    cph_nxt   = cph_r;
    slot_nxt  = slot_r;
    sslot_nxt = sslot_r;
    ii_nxt    = ii_r;
    jj_nxt    = jj_r;
    col0_nxt  = col0_r;
    pos_nxt   = pos_r;
    lastw_nxt = lastw_r;
    tag_nxt.valid = ram_re;
    tag_nxt.pos   = pos_r;

    if (restart) begin
      row_nxt  = '0;
      col_nxt  = '0;
      rph_nxt  = '0;
      cph_nxt  = '0;
      slot_nxt = '0;
    end else if (accept) begin
      if (fire) begin
        sslot_nxt = sstart[mpa_pkg::WIN_W-1:0];
        ii_nxt    = '0;
        jj_nxt    = '0;
        pos_nxt   = '0;
        col0_nxt  = mpa_pkg::COL_W'(c_inc - mpa_pkg::CDIM_W'(cfg.win_cols));
        lastw_nxt = ((mpa_pkg::RDIM_W'(row_r) + mpa_pkg::RDIM_W'(cfg.stride)) >= cfg.rows) &&
                    ((mpa_pkg::CDIM1_W'(col_r) + mpa_pkg::CDIM1_W'(cfg.stride)) >=
                     mpa_pkg::CDIM1_W'(cfg.cols));
      end
      if (c_inc >= cfg.cols) begin
        col_nxt = '0;
        cph_nxt = '0;
        if (r_inc >= cfg.rows) begin
          row_nxt  = '0;
          rph_nxt  = '0;
          slot_nxt = '0;
        end else begin
          rph_nxt  = mpa_pkg::next_phase(mpa_pkg::DIM_W'(row_r), cfg.win_rows, rph_r,
                                         cfg.stride);
          row_nxt  = r_inc[mpa_pkg::ROW_W-1:0];
          slot_nxt = slot_inc;
        end
      end else begin
        cph_nxt = mpa_pkg::next_phase(mpa_pkg::DIM_W'(col_r), cfg.win_cols, cph_r,
                                      cfg.stride);
        col_nxt = c_inc[mpa_pkg::COL_W-1:0];
      end
    end

    // Row-major walk over the window
    if (ram_re) begin
      pos_nxt = pos_r + mpa_pkg::POS_W'(1);
      if (mpa_pkg::WIN_REG_W'(jj_r) == cfg.win_cols - mpa_pkg::WIN_REG_W'(1)) begin
        jj_nxt    = '0;
        ii_nxt    = ii_r + mpa_pkg::WIN_W'(1);
        sslot_nxt = sslot_inc;
      end else begin
        jj_nxt = jj_r + mpa_pkg::WIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpa_pkg::ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      rph_r   <= '0;
      cph_r   <= '0;
      slot_r  <= '0;
      tag_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      rph_r   <= rph_nxt;
      cph_r   <= cph_nxt;
      slot_r  <= slot_nxt;
      tag_r   <= tag_nxt;
    end
  end

  // Scan datapath, no reset needed
  always_ff @(posedge clk) begin
    sslot_r <= sslot_nxt;
    ii_r    <= ii_nxt;
    jj_r    <= jj_nxt;
    col0_r  <= col0_nxt;
    pos_r   <= pos_nxt;
    lastw_r <= lastw_nxt;
  end

  // Tag lines up with the registered read data
  assign rd_tag = tag_r;

endmodule

// ===== hw/rtl/mpa_argmax.sv =====
module mpa_argmax (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mpa_pkg::rd_tag_t                        rd_tag,
  input  logic [mpa_pkg::SAMPLE_WIDTH-1:0]        rd_data,
  input  mpa_pkg::res_ctl_t                       res_ctl,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic                                    out_free,
  output logic signed [mpa_pkg::SAMPLE_WIDTH-1:0] max_value,
  output logic [mpa_pkg::POS_OUT_W-1:0]           max_position,
  output logic                                    last_window
);

  logic signed [mpa_pkg::SAMPLE_WIDTH-1:0] best_r, best_nxt;
  logic [mpa_pkg::POS_W-1:0]               bpos_r, bpos_nxt;
  logic                                    take;

  logic                                    ovalid_r, ovalid_nxt;
  logic signed [mpa_pkg::SAMPLE_WIDTH-1:0] oval_r;
  logic [mpa_pkg::POS_OUT_W-1:0]           opos_r;
  logic                                    olast_r;

  // Strict compare keeps the first maximum; first read always takes
  always_comb begin
    take     = rd_tag.valid &&
               ((rd_tag.pos == '0) || ($signed(rd_data) > best_r));
    best_nxt = take ? $signed(rd_data) : best_r;
    bpos_nxt = take ? rd_tag.pos : bpos_r;
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    bpos_r <= bpos_nxt;
  end

  // Result register
  assign out_free = !ovalid_r || out_ready;

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (res_ctl.load) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ctl.load) begin
      oval_r  <= best_nxt;
      opos_r  <= mpa_pkg::POS_OUT_W'(bpos_nxt);
      olast_r <= res_ctl.last_window;
    end
  end

  assign out_valid    = ovalid_r;
  assign max_value    = oval_r;
  assign max_position = opos_r;
  assign last_window  = olast_r;

endmodule

// ===== hw/rtl/max_pooling_2d_with_argmax_top.sv =====
// Timing: a sample that closes no window is only written to the line store; one that
//   closes a window starts a scan of it, and its result is loaded after the last read.
// Throughput: 1 sample per cycle while idle; a closing sample holds off input through
//   the window scan and drain, more while the result register is full.
// Reset: synchronous active-low rst_n clears counters, handshake state and
//   restores default registers; the line store is not cleared.
`include "max_pooling_2d_with_argmax_top_defines.svh"

module max_pooling_2d_with_argmax_top (
  input  logic             clk,
  input  logic             rst_n,
  mpa_cfg_if.sink          cfg_wr,
  mpa_in_if.sink           in_req,
  mpa_out_if.source        out_res
);

  mpa_pkg::cfg_t                    cfg;
  logic                             restart;
  logic                             out_free;
  logic                             ram_we;
  logic [mpa_pkg::ADDR_W-1:0]       ram_waddr;
  logic [mpa_pkg::SAMPLE_WIDTH-1:0] ram_wdata;
  logic                             ram_re;
  logic [mpa_pkg::ADDR_W-1:0]       ram_raddr;
  logic [mpa_pkg::SAMPLE_WIDTH-1:0] ram_rdata;
  mpa_pkg::rd_tag_t                 rd_tag;
  mpa_pkg::res_ctl_t                res_ctl;
  logic                             scan_active;

  // Register file
  mpa_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_wr.valid),
    .wr_index (cfg_wr.index),
    .wr_data  (cfg_wr.data),
    .wr_ready (cfg_wr.ready),
    .cfg      (cfg),
    .restart  (restart)
  );

  // Frame counters and window sequencer
  mpa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .restart     (restart),
    .in_valid    (in_req.valid),
    .in_sample   (in_req.sample),
    .in_ready    (in_req.ready),
    .out_free    (out_free),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .rd_tag      (rd_tag),
    .res_ctl     (res_ctl),
    .scan_active (scan_active)
  );

  // Line store: MAX_WINDOW rows of MAX_FRAME_COLS samples
  mpa_ram #(
    .WIDTH (mpa_pkg::SAMPLE_WIDTH),
    .DEPTH (mpa_pkg::STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Max / argmax and result register
  mpa_argmax u_argmax (
    .clk          (clk),
    .rst_n        (rst_n),
    .rd_tag       (rd_tag),
    .rd_data      (ram_rdata),
    .res_ctl      (res_ctl),
    .out_ready    (out_res.ready),
    .out_valid    (out_res.valid),
    .out_free     (out_free),
    .max_value    (out_res.max_value),
    .max_position (out_res.max_position),
    .last_window  (out_res.last_window)
  );

  // A result is never loaded over one that has not been taken
  `MPA_ASSERT_IMP(a_no_overwrite, res_ctl.load, !out_res.valid || out_res.ready)
  // Line store reads are in flight only while no sample is taken
  `MPA_ASSERT_IMP(a_read_busy, rd_tag.valid, !in_req.ready)
  // Every scan cycle yields read data in the next cycle
  `MPA_ASSERT_NEXT(a_scan_feeds, scan_active, rd_tag.valid)
  // A new result follows a cycle in which input was held off
  `MPA_ASSERT_IMP(a_result_after_scan, $rose(out_res.valid), !$past(in_req.ready))

endmodule
